>>> design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Opcode and status codes, the word width and the default ring depth.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned DefaultDepth = 128;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [DataW-1:0] word_t;

endpackage

>>> design/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue held in a ring memory
// Pushes and pops at either end of a ring of DEPTH signed words, with
// full and empty reporting on every operation.
// ----------------------------------------------------------------------------
//  Channel   Ports                                          Handshake
//  command   start_i, opcode_i, push_value_i                start_i && !busy_o
//  result    done_o, pop_value_o, status_o, now_empty_o,    done_o, one cycle
//            now_full_o
//
//  A command is taken in any cycle; busy_o stays low, so one word per cycle.
//  Its result appears on the cycle after acceptance, for one cycle only.
//  The ring memory has a registered read port: a pop reads in the accept
//  cycle and the word leaves through that read register on the next one.
//  Reset leaves the deque empty; the ring contents are not cleared.
//  The result side cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              opcode_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] pop_value_o,
  output logic [1:0]              status_o,
  output logic                    now_empty_o,
  output logic                    now_full_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] prev_idx(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  word_t ring_mem [DEPTH];

  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] rear_q, rear_d;
  logic            empty_q, empty_d;

  logic            accept;
  logic            full;
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  status_e         status_d;
  logic            minus_one_d;

  word_t           rd_data_q;
  logic            valid_q;
  logic            from_mem_q;
  logic            minus_one_q;
  status_e         status_q;
  logic            now_empty_q, now_full_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = !empty_q && (next_idx(rear_q) == front_q);

  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rd_en       = 1'b0;
    rd_addr     = front_q;
    status_d    = ST_DONE;
    minus_one_d = 1'b0;
    if (accept) begin
      case (op_e'(opcode_i))
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (full) begin
            status_d = ST_FULL;
          end else if (empty_q) begin
            // First word always lands at entry zero.
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b0;
            wr_en   = 1'b1;
            wr_addr = '0;
          end else if (op_e'(opcode_i) == OP_PUSH_FRONT) begin
            front_d = prev_idx(front_q);
            wr_en   = 1'b1;
            wr_addr = prev_idx(front_q);
          end else begin
            rear_d  = next_idx(rear_q);
            wr_en   = 1'b1;
            wr_addr = next_idx(rear_q);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (empty_q) begin
            status_d    = ST_EMPTY;
            minus_one_d = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = (op_e'(opcode_i) == OP_POP_FRONT) ? front_q : rear_q;
            if (front_q == rear_q) begin
              // Last entry leaves: the deque returns to its reset shape.
              front_d = '0;
              rear_d  = '0;
              empty_d = 1'b1;
            end else if (op_e'(opcode_i) == OP_POP_FRONT) begin
              front_d = next_idx(front_q);
            end else begin
              rear_d = prev_idx(rear_q);
            end
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  // A write and a read of the same entry never share a cycle: one command
  // is either a push or a pop, and the read data is captured at once.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= push_value_i;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_mem_q  <= rd_en;
      minus_one_q <= minus_one_d;
      status_q    <= status_d;
      now_empty_q <= empty_d;
      now_full_q  <= !empty_d && (next_idx(rear_d) == front_d);
    end
  end

  assign done_o      = valid_q;
  assign pop_value_o = from_mem_q  ? rd_data_q :
                       minus_one_q ? '1 : '0;
  assign status_o    = status_q;
  assign now_empty_o = now_empty_q;
  assign now_full_o  = now_full_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted command produced no result");

  a_empty_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (front_q == '0) && (rear_q == '0))
    else $error("empty deque with indices off entry zero");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(now_empty_o && now_full_o))
    else $error("result reports empty and full together");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (now_empty_o && (pop_value_o == '1)))
    else $error("rejected pop with wrong value or flags");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (now_full_o && (pop_value_o == '0)))
    else $error("rejected push with wrong value or flags");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of circular_deque_unit
// Drives push and pop commands at both ends of the deque, mirrors the ring
// in a scoreboard class and compares every returned word and flag.
// ----------------------------------------------------------------------------
module tb
  import cdq_pkg::*;
();

  localparam int unsigned RingDepth = DefaultDepth;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainLimit = 1000;

  typedef struct {
    word_t   pop_value;
    status_e status;
    logic    now_empty;
    logic    now_full;
  } outcome_t;

  // Mirror of the deque: its own ring, indices and empty flag, plus the
  // outcomes still owed by the block in command order.
  class deque_mirror;
    word_t       ring [RingDepth];
    int unsigned head;
    int unsigned tail;
    bit          empty;
    outcome_t    outcome_q [$];
    int unsigned fail_count;

    function new();
      head       = 0;
      tail       = 0;
      empty      = 1'b1;
      fail_count = 0;
    endfunction

    function int unsigned step_up(int unsigned i);
      return (i + 1 >= RingDepth) ? 0 : i + 1;
    endfunction

    function int unsigned step_down(int unsigned i);
      return (i == 0) ? RingDepth - 1 : i - 1;
    endfunction

    function bit is_full();
      return !empty && step_up(tail) == head;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void note_command(op_e op, word_t value);
      outcome_t    o;
      int unsigned at;
      o.pop_value = '0;
      o.status    = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
        if (is_full()) begin
          o.status = ST_FULL;
        end else if (empty) begin
          // The first word always lands at entry zero.
          head    = 0;
          tail    = 0;
          empty   = 1'b0;
          ring[0] = value;
        end else if (op == OP_PUSH_FRONT) begin
          head       = step_down(head);
          ring[head] = value;
        end else begin
          tail       = step_up(tail);
          ring[tail] = value;
        end
      end else begin
        if (empty) begin
          o.status    = ST_EMPTY;
          o.pop_value = -1;
        end else begin
          at          = (op == OP_POP_FRONT) ? head : tail;
          o.pop_value = ring[at];
          if (head == tail) begin
            head  = 0;
            tail  = 0;
            empty = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            head = step_up(head);
          end else begin
            tail = step_down(tail);
          end
        end
      end
      o.now_empty = empty;
      o.now_full  = is_full();
      outcome_q.push_back(o);
    endfunction

    function void check_outcome(word_t pop_value, logic [1:0] status, logic now_empty,
                                logic now_full);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("tb: unexpected result word pop_value=%0d status=%0d", pop_value, status);
        return;
      end
      o = outcome_q.pop_front();
      if (pop_value !== o.pop_value || status !== o.status ||
          now_empty !== o.now_empty || now_full !== o.now_full) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("tb: mismatch expected value=%0d status=%0d empty=%0b full=%0b",
                   o.pop_value, o.status, o.now_empty, o.now_full);
          $display("tb:          got      value=%0d status=%0d empty=%0b full=%0b",
                   pop_value, status, now_empty, now_full);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        opcode_i;
  logic signed [DataW-1:0] push_value_i;
  logic              done_o;
  logic signed [DataW-1:0] pop_value_o;
  logic [1:0]        status_o;
  logic              now_empty_o;
  logic              now_full_o;

  deque_mirror mirror;

  circular_deque_unit #(
    .DEPTH(RingDepth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .push_value_i(push_value_i),
    .done_o      (done_o),
    .pop_value_o (pop_value_o),
    .status_o    (status_o),
    .now_empty_o (now_empty_o),
    .now_full_o  (now_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A result belongs to a word taken on an earlier edge, so it is checked
  // before the word accepted on this edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) mirror.check_outcome(pop_value_o, status_o, now_empty_o, now_full_o);
      if (start_i && !busy_o) mirror.note_command(op_e'(opcode_i), push_value_i);
    end
  end

  task automatic send_word(op_e op, word_t value);
    start_i      <= 1'b1;
    opcode_i     <= op;
    push_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic hold_off(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // push_pct biases the mix so phases fill the ring, drain it or hover.
  task automatic run_phase(int unsigned count, int unsigned push_pct, bit with_gaps);
    op_e op;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < push_pct)
        op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      else
        op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
      send_word(op, pick_value());
      if (with_gaps && $urandom_range(0, 9) == 0) hold_off($urandom_range(1, 19));
    end
  endtask

  initial begin
    int unsigned waited;
    mirror       = new();
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    opcode_i     = OP_PUSH_FRONT;
    push_value_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on an empty deque, a push into an empty one, the extreme words,
    // the pop of the last entry and a mix of both ends.
    send_word(OP_POP_FRONT, 32'sd5);
    send_word(OP_POP_REAR, -1);
    send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_word(OP_PUSH_REAR, 32'sh8000_0000);
    send_word(OP_PUSH_FRONT, '0);
    send_word(OP_PUSH_REAR, -1);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_REAR, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_REAR, '0);
    send_word(OP_POP_REAR, '0);
    send_word(OP_PUSH_REAR, 32'sd1);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PUSH_FRONT, 32'sh5555_5555);
    send_word(OP_PUSH_FRONT, 32'shAAAA_AAAA);
    send_word(OP_PUSH_REAR, 32'sh0F0F_F0F0);
    send_word(OP_POP_REAR, '0);
    send_word(OP_POP_REAR, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_FRONT, '0);

    run_phase(200, 92, 1'b1);
    run_phase(200, 8, 1'b1);

    // Let the deque settle completely before the next phase.
    start_i <= 1'b0;
    do @(negedge clk_i); while (mirror.pending() != 0);
    @(posedge clk_i);

    run_phase(150, 50, 1'b1);
    run_phase(200, 95, 1'b0);
    run_phase(150, 50, 1'b1);
    run_phase(200, 5, 1'b1);
    run_phase(150, 70, 1'b1);
    run_phase(100, 50, 1'b1);
    run_phase(200, 50, 1'b0);
    start_i <= 1'b0;

    waited = 0;
    while (mirror.pending() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);

    if (mirror.fail_count == 0 && mirror.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
design/cdq_pkg.sv
design/circular_deque_unit.sv
tb/sv/tb.sv
